// ===== rtl/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants of the text console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int MAX_COLS_DEF   = 128;
    localparam int MAX_ROWS_DEF   = 96;
    localparam int REGION_W_LIMIT = 128;
    localparam int REGION_H_LIMIT = 96;
    // widest address sum: row (<= 255) * pitch (<= 255) + column (<= 255)
    localparam int ASUM_W         = 17;
    localparam logic [7:0] BLANK_CHAR = 8'h20;

    typedef enum logic [2:0] {
        OP_PUT    = 3'd0,
        OP_SETCUR = 3'd1,
        OP_SCROLL = 3'd2,
        OP_FILL   = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        CFG_SCREEN_COLS = 3'd0,
        CFG_SCREEN_ROWS = 3'd1,
        CFG_REG_LEFT    = 3'd2,
        CFG_REG_TOP     = 3'd3,
        CFG_REG_WIDTH   = 3'd4,
        CFG_REG_HEIGHT  = 3'd5,
        CFG_COLOR       = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  screen_cols;
        logic [6:0]  screen_rows;
        logic [6:0]  reg_left;
        logic [6:0]  reg_top;
        logic [7:0]  reg_width;
        logic [6:0]  reg_height;
        logic [15:0] color;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUT_MUL,
        S_PUT_WR,
        S_CUR,
        S_SC_ROW,
        S_SC_SRC,
        S_SC_CELL,
        S_SC_WR,
        S_RD_MUL,
        S_RD_ISSUE,
        S_RD_DATA,
        S_DONE
    } t_state;

endpackage

// ===== rtl/text_console_cell_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text console engine over a character/color cell store with a cursor.
// ----------------------------------------------------------------------------
// One command beat in, one result beat out. Scroll and fill walk the active
// region one cell at a time through the single cell store: each copied cell
// is read then written back, each cleared or filled cell is written once,
// and each row's addresses are formed first with the shared 8x8 multiplier,
// a destination product for every row and a source product for a copied row.
// A cursor set or put that runs off the bottom of the region runs the same
// scroll walk before its result beat. The next command can be taken in the
// cycle after the previous one has moved its result to the output register.
// Cells are addressed as row * screen_columns + column;
// cells at or beyond MAX_COLS*MAX_ROWS are never written and read back as
// zero, and a cell must be written before it is read. Config writes are
// accepted at any time but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
    parameter int MAX_COLS = tccw_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tccw_pkg::MAX_ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: op[2:0], char_code[10:3], pos_x[19:11], pos_y[28:20],
    //        scroll_rows[35:29], zero pad[39:36]
    input  logic [39:0] s_axis_tdata,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: cursor_col[6:0], cursor_row[13:7], cell_char[21:14],
    //        cell_color[37:22], zero pad[39:38]
    output logic [39:0] m_axis_tdata
);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = tccw_pkg::ASUM_W;

    tccw_pkg::t_cfg cfg;

    tccw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );
    assign o_cfg_ready = 1'b1;

    // memory port signals
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [23:0]   mem_wdata, mem_rdata;

    tccw_cell_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // effective region size: width 1..128, height 1..96
    logic [7:0] eff_w;
    logic [6:0] eff_h;
    always_comb begin
        if (cfg.reg_width == 8'd0) begin
            eff_w = 8'd1;
        end else if (cfg.reg_width > 8'(tccw_pkg::REGION_W_LIMIT)) begin
            eff_w = 8'(tccw_pkg::REGION_W_LIMIT);
        end else begin
            eff_w = cfg.reg_width;
        end
        if (cfg.reg_height == 7'd0) begin
            eff_h = 7'd1;
        end else if (cfg.reg_height > 7'(tccw_pkg::REGION_H_LIMIT)) begin
            eff_h = 7'(tccw_pkg::REGION_H_LIMIT);
        end else begin
            eff_h = cfg.reg_height;
        end
    end

    tccw_pkg::t_state r_state, n_state;

    // command latch
    logic [2:0]  r_op;
    logic [7:0]  r_ch;
    logic [8:0]  r_px, r_py;
    // cursor and cursor-set operands
    logic [6:0]  r_cx, r_cy;
    logic [9:0]  r_sx, r_sy;
    // region walk
    logic [6:0]  r_r, r_c;
    logic [8:0]  r_n;
    logic        r_fill;
    logic [7:0]  r_wch;
    logic [15:0] r_dmul, r_smul;
    logic        r_src_ok;
    // read result and output register
    logic [23:0] r_rd;
    logic        r_out_valid;
    logic [39:0] r_out;

    // shared row multiplier; product is registered before use
    logic [7:0]  mul_row;
    logic [15:0] mul_out;
    logic [9:0]  r_plus_n;
    logic        copy_row;
    always_comb begin
        r_plus_n = {3'd0, r_r} + {1'b0, r_n};
        copy_row = !r_fill && (r_plus_n < {3'd0, eff_h});
        unique case (r_state)
            tccw_pkg::S_PUT_MUL: mul_row = {1'b0, cfg.reg_top} + {1'b0, r_cy};
            tccw_pkg::S_SC_SRC:  mul_row = 8'({1'b0, cfg.reg_top} + r_plus_n);
            tccw_pkg::S_RD_MUL:  mul_row = r_py[7:0];
            default:             mul_row = {1'b0, cfg.reg_top} + {1'b0, r_r};
        endcase
        mul_out = mul_row * cfg.screen_cols;
    end

    // cell addresses
    logic [SW-1:0] dst_addr, src_addr, rd_addr;
    logic          dst_ok, src_ok, rd_ok;
    logic          last_c, last_r;
    always_comb begin
        dst_addr = SW'(r_dmul) + SW'(cfg.reg_left) + SW'(r_c);
        src_addr = SW'(r_smul) + SW'(cfg.reg_left) + SW'(r_c);
        rd_addr  = SW'(r_dmul) + SW'(r_px[7:0]);
        dst_ok   = dst_addr < SW'(DEPTH);
        src_ok   = src_addr < SW'(DEPTH);
        rd_ok    = rd_addr < SW'(DEPTH);
        last_c   = {1'b0, r_c} == eff_w - 8'd1;
        last_r   = r_r == eff_h - 7'd1;
    end

    // cursor-set rule applied to (r_sx, r_sy)
    logic       cs_xbig;
    logic [9:0] cs_y;
    logic       cs_ybig;
    logic [6:0] cs_x_new, cs_y_new;
    logic [8:0] cs_n;
    always_comb begin
        cs_xbig = !r_sx[9] && ($signed(r_sx) >= $signed({2'b0, eff_w}));
        cs_y    = cs_xbig ? r_sy + 10'd1 : r_sy;
        cs_ybig = !cs_y[9] && ($signed(cs_y) >= $signed({3'b0, eff_h}));
        cs_x_new = (r_sx[9] || cs_xbig) ? 7'd0 : r_sx[6:0];
        if (cs_y[9]) begin
            cs_y_new = 7'd0;
        end else if (cs_ybig) begin
            cs_y_new = eff_h - 7'd1;
        end else begin
            cs_y_new = cs_y[6:0];
        end
        cs_n = 9'(cs_y - {3'b0, eff_h} + 10'd1);
    end

    // next state and memory control
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = dst_addr[AW-1:0];
        mem_raddr = src_addr[AW-1:0];
        mem_wdata = {cfg.color, r_wch};
        unique case (r_state)
            tccw_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (s_axis_tdata[2:0])
                        tccw_pkg::OP_PUT:    n_state = tccw_pkg::S_PUT_MUL;
                        tccw_pkg::OP_SETCUR: n_state = tccw_pkg::S_CUR;
                        tccw_pkg::OP_SCROLL: n_state = (s_axis_tdata[35:29] == 7'd0)
                                                 ? tccw_pkg::S_DONE : tccw_pkg::S_SC_ROW;
                        tccw_pkg::OP_FILL:   n_state = tccw_pkg::S_SC_ROW;
                        tccw_pkg::OP_READ:   n_state = (s_axis_tdata[19] || s_axis_tdata[28])
                                                 ? tccw_pkg::S_DONE : tccw_pkg::S_RD_MUL;
                        default:             n_state = tccw_pkg::S_DONE;
                    endcase
                end
            end
            tccw_pkg::S_PUT_MUL: n_state = tccw_pkg::S_PUT_WR;
            tccw_pkg::S_PUT_WR: begin
                mem_we    = dst_ok;
                mem_wdata = {cfg.color, r_ch};
                n_state   = tccw_pkg::S_CUR;
            end
            tccw_pkg::S_CUR: begin
                n_state = cs_ybig ? tccw_pkg::S_SC_ROW : tccw_pkg::S_DONE;
            end
            tccw_pkg::S_SC_ROW: begin
                n_state = copy_row ? tccw_pkg::S_SC_SRC : tccw_pkg::S_SC_CELL;
            end
            tccw_pkg::S_SC_SRC: n_state = tccw_pkg::S_SC_CELL;
            tccw_pkg::S_SC_CELL: begin
                if (copy_row) begin
                    mem_re  = src_ok;
                    n_state = tccw_pkg::S_SC_WR;
                end else begin
                    mem_we = dst_ok;
                    if (last_c) begin
                        n_state = last_r ? tccw_pkg::S_DONE : tccw_pkg::S_SC_ROW;
                    end
                end
            end
            tccw_pkg::S_SC_WR: begin
                mem_we    = dst_ok;
                mem_wdata = r_src_ok ? mem_rdata : 24'd0;
                if (last_c) begin
                    n_state = last_r ? tccw_pkg::S_DONE : tccw_pkg::S_SC_ROW;
                end else begin
                    n_state = tccw_pkg::S_SC_CELL;
                end
            end
            tccw_pkg::S_RD_MUL: n_state = tccw_pkg::S_RD_ISSUE;
            tccw_pkg::S_RD_ISSUE: begin
                mem_re    = rd_ok;
                mem_raddr = rd_addr[AW-1:0];
                n_state   = tccw_pkg::S_RD_DATA;
            end
            tccw_pkg::S_RD_DATA: n_state = tccw_pkg::S_DONE;
            tccw_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = tccw_pkg::S_IDLE;
                end
            end
            default: n_state = tccw_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tccw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // cursor and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx        <= 7'd0;
            r_cy        <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == tccw_pkg::S_CUR) begin
                r_cx <= cs_x_new;
                r_cy <= cs_y_new;
            end
            if (r_state == tccw_pkg::S_DONE && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tccw_pkg::S_IDLE: begin
                r_op   <= s_axis_tdata[2:0];
                r_ch   <= s_axis_tdata[10:3];
                r_px   <= s_axis_tdata[19:11];
                r_py   <= s_axis_tdata[28:20];
                r_sx   <= {s_axis_tdata[19], s_axis_tdata[19:11]};
                r_sy   <= {s_axis_tdata[28], s_axis_tdata[28:20]};
                r_n    <= {2'b0, s_axis_tdata[35:29]};
                r_fill <= s_axis_tdata[2:0] == tccw_pkg::OP_FILL;
                r_wch  <= (s_axis_tdata[2:0] == tccw_pkg::OP_FILL)
                          ? s_axis_tdata[10:3] : tccw_pkg::BLANK_CHAR;
                r_r    <= 7'd0;
                r_c    <= 7'd0;
                r_rd   <= 24'd0;
            end
            tccw_pkg::S_PUT_MUL: begin
                // put writes at the cursor column
                r_dmul <= mul_out;
                r_c    <= r_cx;
            end
            tccw_pkg::S_PUT_WR: begin
                r_sx <= 10'(r_cx) + 10'd1;
                r_sy <= 10'(r_cy);
            end
            tccw_pkg::S_CUR: begin
                r_n <= cs_n;
                r_c <= 7'd0;
            end
            tccw_pkg::S_SC_ROW: r_dmul <= mul_out;
            tccw_pkg::S_SC_SRC: r_smul <= mul_out;
            tccw_pkg::S_SC_CELL: begin
                r_src_ok <= src_ok;
                if (!copy_row) begin
                    if (last_c) begin
                        r_c <= 7'd0;
                        r_r <= r_r + 7'd1;
                    end else begin
                        r_c <= r_c + 7'd1;
                    end
                end
            end
            tccw_pkg::S_SC_WR: begin
                if (last_c) begin
                    r_c <= 7'd0;
                    r_r <= r_r + 7'd1;
                end else begin
                    r_c <= r_c + 7'd1;
                end
            end
            tccw_pkg::S_RD_MUL: r_dmul <= mul_out;
            tccw_pkg::S_RD_ISSUE: r_src_ok <= rd_ok;
            tccw_pkg::S_RD_DATA: r_rd <= r_src_ok ? mem_rdata : 24'd0;
            tccw_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    r_out <= {2'b0, r_rd, r_cy, r_cx};
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = r_state == tccw_pkg::S_IDLE;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // command opcode is held for the whole command; keep it visible for debug
    logic unused_ok;
    assign unused_ok = ^{r_op, cfg.screen_rows};
endmodule

// ===== rtl/tccw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tccw_cfg_regs
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
module tccw_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  logic [2:0]         i_index,
    input  logic [15:0]        i_data,
    output tccw_pkg::t_cfg     o_cfg
);
    tccw_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_cols <= 8'd80;
            r_cfg.screen_rows <= 7'd60;
            r_cfg.reg_left    <= 7'd0;
            r_cfg.reg_top     <= 7'd0;
            r_cfg.reg_width   <= 8'd80;
            r_cfg.reg_height  <= 7'd60;
            r_cfg.color       <= 16'h0704;
        end else if (i_wr) begin
            case (tccw_pkg::t_cfg_idx'(i_index))
                tccw_pkg::CFG_SCREEN_COLS: r_cfg.screen_cols <= i_data[7:0];
                tccw_pkg::CFG_SCREEN_ROWS: r_cfg.screen_rows <= i_data[6:0];
                tccw_pkg::CFG_REG_LEFT:    r_cfg.reg_left    <= i_data[6:0];
                tccw_pkg::CFG_REG_TOP:     r_cfg.reg_top     <= i_data[6:0];
                tccw_pkg::CFG_REG_WIDTH:   r_cfg.reg_width   <= i_data[7:0];
                tccw_pkg::CFG_REG_HEIGHT:  r_cfg.reg_height  <= i_data[6:0];
                tccw_pkg::CFG_COLOR:       r_cfg.color       <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== rtl/tccw_cell_mem.sv =====
// ----------------------------------------------------------------------------
// tccw_cell_mem
// Cell store: one word per cell, color above character, registered read.
// ----------------------------------------------------------------------------
module tccw_cell_mem #(
    parameter int DEPTH = tccw_pkg::MAX_COLS_DEF * tccw_pkg::MAX_ROWS_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [23:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [23:0]   o_rdata
);
    logic [23:0] mem [DEPTH];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
